// ===== src/frx_pkg.sv =====
// frx_pkg: shared types and constants of the fragment reassembly receiver
// used by the channel interfaces and by fragment_reassembler_rx_top
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package frx_pkg;

    // fragment layout
    localparam int PAYLOAD_PER_FRAGMENT = 1024;
    localparam int MAX_FRAGMENT_LENGTH  = 1032;
    localparam int HEADER_BYTES         = 8;

    // field widths
    localparam int BYTE_W   = 8;
    localparam int LEN_W    = 13;
    localparam int SIZE_W   = 32;
    localparam int BUF_W    = 19;
    localparam int ADDR_W   = 18;
    localparam int KIND_W   = 3;
    localparam int CNT_W    = 8;
    localparam int REG_IDX_W = 8;

    // largest usable buffer size for write dropping
    localparam logic [BUF_W-1:0] ADDR_LIMIT = BUF_W'(262144);

    // width of the address sum before truncation
    localparam int ADDR_CALC_W =
        $clog2(256 * PAYLOAD_PER_FRAGMENT + (1 << LEN_W)) + 1;

    // count saturation value
    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    // header byte positions
    localparam logic [2:0] HDR_FRAME_ID = 3'd0;
    localparam logic [2:0] HDR_INDEX    = 3'd1;
    localparam logic [2:0] HDR_TOTAL    = 3'd2;
    localparam logic [2:0] HDR_SIZE_B3  = 3'd4;
    localparam logic [2:0] HDR_SIZE_B2  = 3'd5;
    localparam logic [2:0] HDR_SIZE_B1  = 3'd6;
    localparam logic [2:0] HDR_SIZE_B0  = 3'd7;

    // output queue
    localparam int FIFO_DEPTH = 4;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int FCNT_W     = $clog2(FIFO_DEPTH + 1);

    // configuration register indexes
    typedef enum logic [REG_IDX_W-1:0] {
        REG_BUFFER_ATTACHED = 8'd0,
        REG_RX_BUFFER_SIZE  = 8'd1
    } t_reg_idx;

    // receive phase
    typedef enum logic [1:0] {
        PH_LEN_HI = 2'd0,
        PH_LEN_LO = 2'd1,
        PH_BODY   = 2'd2
    } t_phase;

    // result kinds
    typedef enum logic [KIND_W-1:0] {
        KIND_WRITE      = 3'd0,
        KIND_FRAG_OK    = 3'd1,
        KIND_FRAME_DONE = 3'd2,
        KIND_BAD_LEN    = 3'd3,
        KIND_MALFORMED  = 3'd4
    } t_kind;

    typedef struct packed {
        t_kind              kind;
        logic [ADDR_W-1:0]  write_address;
        logic [BYTE_W-1:0]  write_data;
        logic [SIZE_W-1:0]  frame_size;
        logic [CNT_W-1:0]   fragments_seen;
        logic               last;
    } t_result;

endpackage

`default_nettype wire

// ===== src/frx_if.sv =====
// frx_if: valid/ready channel interfaces of the fragment reassembly receiver
// byte input, result output and configuration write; depends on frx_pkg
`timescale 1ns / 1ps
`default_nettype none

// received byte channel
interface frx_byte_if;
    logic                       valid;
    logic                       ready;
    logic [frx_pkg::BYTE_W-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

// result channel
interface frx_result_if;
    logic                       valid;
    logic                       ready;
    logic [frx_pkg::KIND_W-1:0] kind;
    logic [frx_pkg::ADDR_W-1:0] write_address;
    logic [frx_pkg::BYTE_W-1:0] write_data;
    logic [frx_pkg::SIZE_W-1:0] frame_size;
    logic [frx_pkg::CNT_W-1:0]  fragments_seen;
    logic                       last;

    modport source (output valid, output kind, output write_address, output write_data,
                    output frame_size, output fragments_seen, output last, input ready);
    modport sink   (input valid, input kind, input write_address, input write_data,
                    input frame_size, input fragments_seen, input last, output ready);
endinterface

// configuration write channel
interface frx_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [frx_pkg::REG_IDX_W-1:0] reg_index;
    logic [frx_pkg::BUF_W-1:0]     wr_data;

    modport source (output valid, output reg_index, output wr_data, input ready);
    modport sink   (input valid, input reg_index, input wr_data, output ready);
endinterface

`default_nettype wire

// ===== src/fragment_reassembler_rx_top.sv =====
// fragment_reassembler_rx_top: fragment reassembly receiver, byte parser and result queue
// depends on frx_pkg and the interfaces in frx_if.sv
//
// usage
//   i_byte carries the received stream one byte per request: a big-endian
//   two-byte length prefix, an eight-byte header, then payload bytes.
//   o_result carries buffer writes and per-fragment status results; the
//   last flag marks the final result caused by one byte (at most two).
//   i_cfg writes buffer_attached (index 0) and rx_buffer_size (index 1);
//   it is always ready and is meant to be written while the block is idle.
// timing
//   a byte is parsed in the cycle it is accepted; its results are registered in
//   a four-entry output queue; throughput is one byte per cycle while i_byte.ready
//   is high, and the queue drains one result per cycle while o_result.ready is high;
//   i_byte.ready is high while the queue holds two results or fewer
// reset
//   synchronous active-low i_rst_n: waits for a length prefix, frame state
//   cleared, current frame id 255, buffer attached with 262144 bytes
// stall
//   when o_result.ready stays low the queue fills and i_byte.ready drops;
//   no result is lost or reordered
`timescale 1ns / 1ps
`default_nettype none

module fragment_reassembler_rx_top (
    input  wire             i_clk,
    input  wire             i_rst_n,
    frx_byte_if.sink        i_byte,
    frx_cfg_if.sink         i_cfg,
    frx_result_if.source    o_result
);
    import frx_pkg::*;

    // configuration
    logic               r_buffer_attached;
    logic [BUF_W-1:0]   r_rx_buffer_size;

    // parser state
    t_phase             r_phase, n_phase;
    logic [BYTE_W-1:0]  r_length_high, n_length_high;
    logic [LEN_W-1:0]   r_fragment_length, n_fragment_length;
    logic [LEN_W-1:0]   r_byte_position, n_byte_position;
    logic [BYTE_W-1:0]  r_hdr_frame_id, n_hdr_frame_id;
    logic [BYTE_W-1:0]  r_hdr_index, n_hdr_index;
    logic [BYTE_W-1:0]  r_hdr_total, n_hdr_total;
    logic [SIZE_W-1:0]  r_hdr_size, n_hdr_size;
    logic [BYTE_W-1:0]  r_cur_frame_id, n_cur_frame_id;
    logic [BYTE_W-1:0]  r_cur_total, n_cur_total;
    logic [CNT_W-1:0]   r_frag_count, n_frag_count;
    logic [SIZE_W-1:0]  r_frame_size, n_frame_size;

    // output queue
    t_result            r_fifo [FIFO_DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr, r_rd_ptr;
    logic [FCNT_W-1:0]  r_count, n_count;

    // per-byte results
    t_result            res0, res1;
    logic [1:0]         push_n;
    logic               byte_acc, pop;

    // datapath temporaries
    logic [15:0]            len_full;
    logic                   len_bad;
    logic [LEN_W:0]         pos_next;
    logic [ADDR_CALC_W-1:0] addr_calc;
    logic [BUF_W-1:0]       limit;
    logic                   wr_en;
    logic                   frag_end;
    t_kind                  end_kind;

    assign byte_acc     = i_byte.valid && i_byte.ready;
    assign pop          = o_result.valid && o_result.ready;
    assign i_byte.ready = (r_count <= FCNT_W'(FIFO_DEPTH - 2));
    assign i_cfg.ready  = 1'b1;

    // length decode and position helpers
    assign len_full = {r_length_high, i_byte.rx_byte};
    assign len_bad  = (len_full == 16'd0) || (len_full > 16'(MAX_FRAGMENT_LENGTH));
    assign pos_next = {1'b0, r_byte_position} + 1'b1;
    assign frag_end = (pos_next >= {1'b0, r_fragment_length});
    assign limit    = (r_rx_buffer_size > ADDR_LIMIT) ? ADDR_LIMIT : r_rx_buffer_size;
    assign addr_calc = ADDR_CALC_W'(r_hdr_index) * ADDR_CALC_W'(PAYLOAD_PER_FRAGMENT)
                     + ADDR_CALC_W'(r_byte_position - LEN_W'(HEADER_BYTES));
    assign wr_en = (r_byte_position >= LEN_W'(HEADER_BYTES)) && r_buffer_attached
                && (r_hdr_index < r_hdr_total) && (addr_calc < ADDR_CALC_W'(limit));

    // next phase
    always_comb begin
        n_phase = r_phase;
        if (byte_acc) begin
            case (r_phase)
                PH_LEN_HI: n_phase = PH_LEN_LO;
                PH_LEN_LO: n_phase = len_bad ? PH_LEN_HI : PH_BODY;
                PH_BODY:   n_phase = frag_end ? PH_LEN_HI : PH_BODY;
                default:   n_phase = PH_LEN_HI;
            endcase
        end
    end

    // parser datapath and results
    always_comb begin
        n_length_high     = r_length_high;
        n_fragment_length = r_fragment_length;
        n_byte_position   = r_byte_position;
        n_hdr_frame_id    = r_hdr_frame_id;
        n_hdr_index       = r_hdr_index;
        n_hdr_total       = r_hdr_total;
        n_hdr_size        = r_hdr_size;
        n_cur_frame_id    = r_cur_frame_id;
        n_cur_total       = r_cur_total;
        n_frag_count      = r_frag_count;
        n_frame_size      = r_frame_size;
        end_kind          = KIND_FRAG_OK;
        push_n            = 2'd0;
        res0              = '0;
        res1              = '0;

        if (byte_acc) begin
            case (r_phase)
                PH_LEN_HI: begin
                    n_length_high = i_byte.rx_byte;
                end
                PH_LEN_LO: begin
                    if (len_bad) begin
                        res0.kind           = KIND_BAD_LEN;
                        res0.frame_size     = r_frame_size;
                        res0.fragments_seen = r_frag_count;
                        res0.last           = 1'b1;
                        push_n              = 2'd1;
                    end else begin
                        n_fragment_length = len_full[LEN_W-1:0];
                        n_byte_position   = '0;
                    end
                end
                PH_BODY: begin
                    // header capture
                    if (r_byte_position < LEN_W'(HEADER_BYTES)) begin
                        case (r_byte_position[2:0])
                            HDR_FRAME_ID: n_hdr_frame_id = i_byte.rx_byte;
                            HDR_INDEX:    n_hdr_index    = i_byte.rx_byte;
                            HDR_TOTAL:    n_hdr_total    = i_byte.rx_byte;
                            HDR_SIZE_B3:  n_hdr_size     = {i_byte.rx_byte, 24'd0};
                            HDR_SIZE_B2:  n_hdr_size[23:16] = i_byte.rx_byte;
                            HDR_SIZE_B1:  n_hdr_size[15:8]  = i_byte.rx_byte;
                            HDR_SIZE_B0:  n_hdr_size[7:0]   = i_byte.rx_byte;
                            default:      n_hdr_size     = r_hdr_size;
                        endcase
                    end
                    // payload write
                    if (wr_en) begin
                        res0.kind           = KIND_WRITE;
                        res0.write_address  = addr_calc[ADDR_W-1:0];
                        res0.write_data     = i_byte.rx_byte;
                        res0.frame_size     = r_frame_size;
                        res0.fragments_seen = r_frag_count;
                        res0.last           = !frag_end;
                    end
                    n_byte_position = pos_next[LEN_W-1:0];
                    // end of fragment bookkeeping
                    if (frag_end) begin
                        n_byte_position = '0;
                        if (r_fragment_length < LEN_W'(HEADER_BYTES)) begin
                            end_kind = KIND_MALFORMED;
                        end else begin
                            if ((n_hdr_frame_id != r_cur_frame_id)
                                    || (n_hdr_total != r_cur_total)) begin
                                n_cur_frame_id = n_hdr_frame_id;
                                n_cur_total    = n_hdr_total;
                                n_frag_count   = '0;
                                n_frame_size   = n_hdr_size;
                            end
                            if (r_buffer_attached && (n_hdr_index < n_hdr_total)
                                    && (n_frag_count != CNT_MAX)) begin
                                n_frag_count = n_frag_count + 1'b1;
                            end
                            if (n_frag_count >= n_cur_total) begin
                                if (n_frame_size > SIZE_W'(r_rx_buffer_size)) begin
                                    n_frame_size = SIZE_W'(r_rx_buffer_size);
                                end
                                end_kind = KIND_FRAME_DONE;
                            end
                        end
                        res1.kind           = end_kind;
                        res1.frame_size     = n_frame_size;
                        res1.fragments_seen = n_frag_count;
                        res1.last           = 1'b1;
                        if (wr_en) begin
                            push_n = 2'd2;
                        end else begin
                            res0   = res1;
                            push_n = 2'd1;
                        end
                    end else if (wr_en) begin
                        push_n = 2'd1;
                    end
                end
                default: begin
                    n_byte_position = '0;
                end
            endcase
        end
    end

    assign n_count = r_count + FCNT_W'(push_n) - FCNT_W'(pop);

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_buffer_attached <= 1'b1;
            r_rx_buffer_size  <= ADDR_LIMIT;
        end else if (i_cfg.valid && i_cfg.ready) begin
            case (t_reg_idx'(i_cfg.reg_index))
                REG_BUFFER_ATTACHED: r_buffer_attached <= i_cfg.wr_data[0];
                REG_RX_BUFFER_SIZE:  r_rx_buffer_size  <= i_cfg.wr_data;
                default: ;
            endcase
        end
    end

    // parser state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase           <= PH_LEN_HI;
            r_length_high     <= '0;
            r_fragment_length <= '0;
            r_byte_position   <= '0;
            r_hdr_frame_id    <= '0;
            r_hdr_index       <= '0;
            r_hdr_total       <= '0;
            r_hdr_size        <= '0;
            r_cur_frame_id    <= 8'd255;
            r_cur_total       <= '0;
            r_frag_count      <= '0;
            r_frame_size      <= '0;
        end else begin
            r_phase           <= n_phase;
            r_length_high     <= n_length_high;
            r_fragment_length <= n_fragment_length;
            r_byte_position   <= n_byte_position;
            r_hdr_frame_id    <= n_hdr_frame_id;
            r_hdr_index       <= n_hdr_index;
            r_hdr_total       <= n_hdr_total;
            r_hdr_size        <= n_hdr_size;
            r_cur_frame_id    <= n_cur_frame_id;
            r_cur_total       <= n_cur_total;
            r_frag_count      <= n_frag_count;
            r_frame_size      <= n_frame_size;
        end
    end

    // queue pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + PTR_W'(push_n);
            r_rd_ptr <= r_rd_ptr + PTR_W'(pop);
            r_count  <= n_count;
        end
    end

    // queue storage
    always_ff @(posedge i_clk) begin
        if (push_n != 2'd0) begin
            r_fifo[r_wr_ptr] <= res0;
        end
        if (push_n == 2'd2) begin
            r_fifo[r_wr_ptr + 1'b1] <= res1;
        end
    end

    // result channel
    assign o_result.valid          = (r_count != '0);
    assign o_result.kind           = r_fifo[r_rd_ptr].kind;
    assign o_result.write_address  = r_fifo[r_rd_ptr].write_address;
    assign o_result.write_data     = r_fifo[r_rd_ptr].write_data;
    assign o_result.frame_size     = r_fifo[r_rd_ptr].frame_size;
    assign o_result.fragments_seen = r_fifo[r_rd_ptr].fragments_seen;
    assign o_result.last           = r_fifo[r_rd_ptr].last;

    // queue never overfills
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FCNT_W'(FIFO_DEPTH))
        else $error("result queue overflow");

    // a length high byte yields no result
    a_len_hi_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (byte_acc && (r_phase == PH_LEN_HI)) |=> (r_count <= $past(r_count)))
        else $error("result pushed for a length high byte");

    // a bad length returns to waiting for a prefix
    a_bad_len_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (byte_acc && (r_phase == PH_LEN_LO) && len_bad) |=> (r_phase == PH_LEN_HI))
        else $error("bad length did not restart prefix parsing");

    // the last fragment byte ends the fragment with position cleared
    a_frag_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (byte_acc && (r_phase == PH_BODY) && frag_end)
            |=> ((r_phase == PH_LEN_HI) && (r_byte_position == '0)))
        else $error("fragment end not handled");

    // the second of two results always closes the byte
    a_pair_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push_n == 2'd2) |-> (res1.last && !res0.last && (res0.kind == KIND_WRITE)))
        else $error("malformed result pair");

endmodule

`default_nettype wire
